[src/assert_macros.svh]
// assertion macros of the operand fetch rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("operand fetch assertion failed");

`define ASSERT_CLK_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("operand fetch reset assertion failed");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)

`define ASSERT_CLK_NR(label, clk, prop)

`endif

`endif

[src/sm83of_pkg.sv]
// types and constants of the sm83 operand fetch unit
// no dependencies
package sm83of_pkg;

  localparam logic [15:0] HighPage = 16'hFF00;

  typedef enum logic {
    FUNC_START = 1'b0,
    FUNC_DATA  = 1'b1
  } func_e;

  typedef enum logic [4:0] {
    MODE_IMP    = 5'd0,
    MODE_R      = 5'd1,
    MODE_R_R    = 5'd2,
    MODE_R_D8   = 5'd3,
    MODE_R_D16  = 5'd4,
    MODE_D16    = 5'd5,
    MODE_MR_R   = 5'd6,
    MODE_R_MR   = 5'd7,
    MODE_R_HLI  = 5'd8,
    MODE_R_HLD  = 5'd9,
    MODE_HLI_R  = 5'd10,
    MODE_HLD_R  = 5'd11,
    MODE_R_A8   = 5'd12,
    MODE_A8_R   = 5'd13,
    MODE_HL_SPR = 5'd14,
    MODE_D8     = 5'd15,
    MODE_A16_R  = 5'd16,
    MODE_D16_R  = 5'd17,
    MODE_MR_D8  = 5'd18,
    MODE_MR     = 5'd19,
    MODE_R_A16  = 5'd20
  } mode_e;

  typedef enum logic [1:0] {
    KIND_REQUEST  = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_ERROR    = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    HL_NONE = 2'd0,
    HL_INC  = 2'd1,
    HL_DEC  = 2'd2
  } hl_step_e;

  typedef struct packed {
    func_e       func;
    logic [4:0]  mode;
    logic [15:0] reg1_value;
    logic [15:0] reg2_value;
    logic        reg1_is_c;
    logic        reg2_is_c;
    logic [15:0] pc_value;
    logic [7:0]  bus_data;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] bus_addr;
    logic [15:0] operand_value;
    logic [15:0] dest_addr;
    logic        dest_in_memory;
    logic [15:0] pc_out;
    hl_step_e    hl_step;
  } result_t;

endpackage

[src/sm83of_ifs.sv]
// valid/ready channel interfaces of the sm83 operand fetch unit
// no dependencies
interface sm83of_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [4:0]  mode;
  logic [15:0] reg1_value;
  logic [15:0] reg2_value;
  logic        reg1_is_c;
  logic        reg2_is_c;
  logic [15:0] pc_value;
  logic [7:0]  bus_data;

  modport source (
    output valid, func, mode, reg1_value, reg2_value, reg1_is_c, reg2_is_c,
    output pc_value, bus_data,
    input  ready
  );
  modport sink (
    input  valid, func, mode, reg1_value, reg2_value, reg1_is_c, reg2_is_c,
    input  pc_value, bus_data,
    output ready
  );
endinterface

interface sm83of_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] bus_addr;
  logic [15:0] operand_value;
  logic [15:0] dest_addr;
  logic        dest_in_memory;
  logic [15:0] pc_out;
  logic [1:0]  hl_step;

  modport source (
    output valid, kind, bus_addr, operand_value, dest_addr, dest_in_memory,
    output pc_out, hl_step,
    input  ready
  );
  modport sink (
    input  valid, kind, bus_addr, operand_value, dest_addr, dest_in_memory,
    input  pc_out, hl_step,
    output ready
  );
endinterface

[src/sm83_operand_fetch_unit.sv]
// sm83 operand fetch unit, top level
// depends on sm83of_pkg, sm83of_ifs, sm83of_in_stage, sm83of_step, assert_macros.svh
//
// in_i carries items: a start (func 0) with mode, register values, C flags
// and pc, or a bus byte (func 1) answering the last read request.
// out_o carries at most one result per item: a bus read request, a complete
// fetch with operand, destination, new pc and hl step, or an unknown mode error.
// bus bytes while nothing is pending, and bytes a mode does not expect, give
// no result. a start while a fetch is pending drops that fetch.
// each item passes an input register, the sequencer logic and a result
// register; one item per cycle sustained, as the input register moves on
// whenever the result register is empty or being emptied.
// reset empties both registers and returns the sequencer to idle; the first
// item may be taken in the cycle after reset is released.
// when the receiver stalls the result holds; one further item waits in the
// input register, then in_i.ready drops until the result is taken.
`include "assert_macros.svh"

module sm83_operand_fetch_unit import sm83of_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sm83of_in_if.sink     in_i,
  sm83of_out_if.source  out_o
);

  logic     s1_valid;
  in_item_t s1_item;
  logic     s1_adv;
  logic     has_result;
  result_t  result;
  logic     out_valid_q, out_valid_d;
  result_t  out_q;

  assign s1_adv = s1_valid && (!out_valid_q || out_o.ready);

  sm83of_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_i),
    .advance_i (s1_adv),
    .valid_o   (s1_valid),
    .item_o    (s1_item)
  );

  sm83of_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (s1_adv),
    .item_i       (s1_item),
    .has_result_o (has_result),
    .result_o     (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = has_result;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && has_result) begin
      out_q <= result;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.kind           = out_q.kind;
  assign out_o.bus_addr       = out_q.bus_addr;
  assign out_o.operand_value  = out_q.operand_value;
  assign out_o.dest_addr      = out_q.dest_addr;
  assign out_o.dest_in_memory = out_q.dest_in_memory;
  assign out_o.pc_out         = out_q.pc_out;
  assign out_o.hl_step        = out_q.hl_step;

  `ASSERT_CLK(a_stalled_item_kept, clk_i, rst_ni, s1_valid && !s1_adv |=> s1_valid)
  `ASSERT_CLK(a_request_clean, clk_i, rst_ni,
              out_o.valid && out_o.kind == KIND_REQUEST |->
              out_o.pc_out == 16'h0000 && out_o.dest_in_memory == 1'b0)
  `ASSERT_CLK(a_dest_zero_off_memory, clk_i, rst_ni,
              out_o.valid && !out_o.dest_in_memory |-> out_o.dest_addr == 16'h0000)
  `ASSERT_CLK_NR(a_reset_empty, clk_i, !rst_ni |-> !out_o.valid)

endmodule

[src/sm83of_in_stage.sv]
// input register of the sm83 operand fetch unit
// depends on sm83of_pkg and sm83of_in_if
module sm83of_in_stage import sm83of_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  sm83of_in_if.sink      in_i,
  input  logic           advance_i,
  output logic           valid_o,
  output in_item_t       item_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     take;

  assign in_i.ready = !valid_q || advance_i;
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.func       <= func_e'(in_i.func);
      item_q.mode       <= in_i.mode;
      item_q.reg1_value <= in_i.reg1_value;
      item_q.reg2_value <= in_i.reg2_value;
      item_q.reg1_is_c  <= in_i.reg1_is_c;
      item_q.reg2_is_c  <= in_i.reg2_is_c;
      item_q.pc_value   <= in_i.pc_value;
      item_q.bus_data   <= in_i.bus_data;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[src/sm83of_step.sv]
// fetch sequencer: holds the pending instruction state and forms at most one result per item
// depends on sm83of_pkg
module sm83of_step import sm83of_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     fire_i,
  input  in_item_t item_i,
  output logic     has_result_o,
  output result_t  result_o
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_BYTE1 = 2'd1,
    PH_BYTE2 = 2'd2,
    PH_BYTE3 = 2'd3
  } phase_e;

  phase_e      phase_q, phase_d;
  mode_e       mode_q, mode_d;
  logic [7:0]  low_q, low_d;
  logic [15:0] pc_q, pc_d;
  logic [15:0] reg1_q, reg1_d;
  logic [15:0] reg2_q, reg2_d;
  logic [15:0] pc1, pc2, word;
  logic [7:0]  d;

  function automatic result_t mk_req(logic [15:0] addr);
    result_t r;
    r          = '0;
    r.kind     = KIND_REQUEST;
    r.bus_addr = addr;
    return r;
  endfunction

  function automatic result_t mk_done(logic [15:0] val, logic [15:0] dest, logic mem,
                                      logic [15:0] pc, hl_step_e step);
    result_t r;
    r                = '0;
    r.kind           = KIND_COMPLETE;
    r.operand_value  = val;
    r.dest_addr      = mem ? dest : 16'h0000;
    r.dest_in_memory = mem;
    r.pc_out         = pc;
    r.hl_step        = step;
    return r;
  endfunction

  assign d    = item_i.bus_data;
  assign pc1  = pc_q + 16'd1;
  assign pc2  = pc_q + 16'd2;
  assign word = {d, low_q};

  always_comb begin
    phase_d      = phase_q;
    mode_d       = mode_q;
    low_d        = low_q;
    pc_d         = pc_q;
    reg1_d       = reg1_q;
    reg2_d       = reg2_q;
    has_result_o = 1'b0;
    result_o     = '0;
    if (fire_i) begin
      if (item_i.func == FUNC_START) begin
        mode_d       = mode_e'(item_i.mode);
        reg1_d       = item_i.reg1_value;
        reg2_d       = item_i.reg2_value;
        pc_d         = item_i.pc_value;
        has_result_o = 1'b1;
        phase_d      = PH_IDLE;
        unique case (mode_e'(item_i.mode))
          MODE_IMP: result_o = mk_done(16'h0000, 16'h0000, 1'b0, item_i.pc_value, HL_NONE);
          MODE_R:   result_o = mk_done(item_i.reg1_value, 16'h0000, 1'b0, item_i.pc_value,
                                       HL_NONE);
          MODE_R_R: result_o = mk_done(item_i.reg2_value, 16'h0000, 1'b0, item_i.pc_value,
                                       HL_NONE);
          MODE_R_D8, MODE_R_D16, MODE_D16, MODE_R_A8, MODE_A8_R, MODE_HL_SPR, MODE_D8,
          MODE_A16_R, MODE_D16_R, MODE_MR_D8, MODE_R_A16: begin
            result_o = mk_req(item_i.pc_value);
            phase_d  = PH_BYTE1;
          end
          MODE_MR_R: result_o = mk_done(item_i.reg2_value,
                                        item_i.reg1_value | (item_i.reg1_is_c ? HighPage
                                                                              : 16'h0000),
                                        1'b1, item_i.pc_value, HL_NONE);
          MODE_R_MR: begin
            result_o = mk_req(item_i.reg2_value | (item_i.reg2_is_c ? HighPage : 16'h0000));
            phase_d  = PH_BYTE1;
          end
          MODE_R_HLI, MODE_R_HLD: begin
            result_o = mk_req(item_i.reg2_value);
            phase_d  = PH_BYTE1;
          end
          MODE_HLI_R: result_o = mk_done(item_i.reg2_value, item_i.reg1_value, 1'b1,
                                         item_i.pc_value, HL_INC);
          MODE_HLD_R: result_o = mk_done(item_i.reg2_value, item_i.reg1_value, 1'b1,
                                         item_i.pc_value, HL_DEC);
          MODE_MR: begin
            result_o = mk_req(item_i.reg1_value);
            phase_d  = PH_BYTE1;
          end
          default: begin
            result_o        = '0;
            result_o.kind   = KIND_ERROR;
            result_o.pc_out = item_i.pc_value;
          end
        endcase
      end else if (phase_q != PH_IDLE) begin
        phase_d      = PH_IDLE;
        has_result_o = 1'b1;
        unique case (phase_q)
          PH_BYTE1: begin
            unique case (mode_q)
              MODE_R_D8, MODE_R_A8, MODE_HL_SPR, MODE_D8:
                result_o = mk_done({8'h00, d}, 16'h0000, 1'b0, pc1, HL_NONE);
              MODE_R_D16, MODE_D16, MODE_A16_R, MODE_D16_R, MODE_R_A16: begin
                low_d    = d;
                result_o = mk_req(pc1);
                phase_d  = PH_BYTE2;
              end
              MODE_R_MR:  result_o = mk_done({8'h00, d}, 16'h0000, 1'b0, pc_q, HL_NONE);
              MODE_R_HLI: result_o = mk_done({8'h00, d}, 16'h0000, 1'b0, pc_q, HL_INC);
              MODE_R_HLD: result_o = mk_done({8'h00, d}, 16'h0000, 1'b0, pc_q, HL_DEC);
              MODE_A8_R:  result_o = mk_done(16'h0000, {8'h00, d} | HighPage, 1'b1, pc1,
                                             HL_NONE);
              MODE_MR_D8: result_o = mk_done({8'h00, d}, reg1_q, 1'b1, pc1, HL_NONE);
              MODE_MR:    result_o = mk_done({8'h00, d}, reg1_q, 1'b1, pc_q, HL_NONE);
              default:    has_result_o = 1'b0;
            endcase
          end
          PH_BYTE2: begin
            unique case (mode_q)
              MODE_R_D16, MODE_D16:
                result_o = mk_done(word, 16'h0000, 1'b0, pc2, HL_NONE);
              MODE_A16_R, MODE_D16_R:
                result_o = mk_done(reg2_q, word, 1'b1, pc2, HL_NONE);
              MODE_R_A16: begin
                result_o = mk_req(word);
                phase_d  = PH_BYTE3;
              end
              default: has_result_o = 1'b0;
            endcase
          end
          PH_BYTE3: begin
            if (mode_q == MODE_R_A16) begin
              result_o = mk_done({8'h00, d}, 16'h0000, 1'b0, pc2, HL_NONE);
            end else begin
              has_result_o = 1'b0;
            end
          end
          default: has_result_o = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mode_q  <= MODE_IMP;
      low_q   <= 8'h00;
      pc_q    <= 16'h0000;
      reg1_q  <= 16'h0000;
      reg2_q  <= 16'h0000;
    end else begin
      phase_q <= phase_d;
      mode_q  <= mode_d;
      low_q   <= low_d;
      pc_q    <= pc_d;
      reg1_q  <= reg1_d;
      reg2_q  <= reg2_d;
    end
  end

endmodule
